/* rtl/core/grc_pkg.sv */
// Shared constants, payload types and controller/datapath command types for the ray caster.
`default_nettype none
package grc_pkg;

  localparam int MAP_DIM    = 8;
  localparam int CELL_SIZE  = 64;
  localparam int MAX_STEPS  = 8;
  localparam int ANGLE_BITS = 12;
  localparam int MAX_RAYS   = 64;

  localparam int CELL_Q     = CELL_SIZE << 7;
  localparam int CELL_SHIFT = $clog2(CELL_Q);
  localparam int MAP_BITS   = $clog2(MAP_DIM);
  localparam int ANG_SHIFT  = 16 - ANGLE_BITS;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

  localparam logic [31:0] WALL_LO_RST = 32'd2979365375;
  localparam logic [31:0] WALL_HI_RST = 32'd4286680453;
  localparam logic [9:0]  SCR_H_RST   = 10'd320;
  localparam logic [6:0]  RAY_CNT_RST = 7'd60;
  localparam logic [7:0]  ANG_STEP_RST = 8'd11;
  localparam logic [10:0] HALF_FOV_RST = 11'd341;

  typedef enum logic [2:0] {
    REG_WALL_LO  = 3'd0,
    REG_WALL_HI  = 3'd1,
    REG_SCR_H    = 3'd2,
    REG_RAY_CNT  = 3'd3,
    REG_ANG_STEP = 3'd4,
    REG_HALF_FOV = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [15:0] viewer_x;
    logic [15:0] viewer_y;
    logic [11:0] viewer_angle;
  } grc_in_t;

  typedef struct packed {
    logic [5:0]  column;
    logic [15:0] hit_x;
    logic [15:0] hit_y;
    logic        wall_side;
    logic        no_hit;
    logic [15:0] distance;
    logic [9:0]  slice_height;
    logic [8:0]  slice_offset;
    logic        last_ray;
  } grc_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SIN_SET,
    OP_SIN_Z2,
    OP_SIN_T1,
    OP_SIN_T2,
    OP_SIN_END,
    OP_TR_INIT,
    OP_TR_MUL,
    OP_TR_DIV,
    OP_TR_TEST,
    OP_D2_A,
    OP_D2_B,
    OP_D2_C,
    OP_SELECT,
    OP_SQ_GO,
    OP_DM_MUL,
    OP_DIST,
    OP_HD_GO,
    OP_HEIGHT,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SEL_S,
    SEL_C,
    SEL_D
  } ang_sel_t;

  typedef struct packed {
    op_t      op;
    ang_sel_t sel;
    logic     axis_v;
  } grc_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic da_zero;
    logic wall;
    logic div_done;
    logic sqrt_done;
    logic miss;
    logic dist_zero;
    logic last;
  } grc_status_t;

endpackage
`default_nettype wire

/* rtl/core/grid_ray_caster_unit.sv */
// Top level of the grid ray caster: controller plus datapath.
`default_nettype none
// A start beat with busy low takes one viewer position and angle and casts ray_count
// rays (capped at 64) over the 8x8 wall map; each ray yields one result beat, a
// single-cycle result_valid strobe that cannot be held off, so the receiver must
// take every beat as it comes. busy stays high until the last ray is issued.
// Per ray: two sine evaluations (a third for the fisheye cosine when a wall is hit),
// then per grid crossing a multiply and a pass through the 32-step serial divider
// (up to 8 crossings per trace, two traces, plus the squared distance of a hit for
// each trace), then a serial square root and a height division. Configuration beats
// are always ready and must only be sent while busy is low.
module grid_ray_caster_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  grc_pkg::grc_in_t  item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              result_valid,
  output grc_pkg::grc_out_t result
);
  import grc_pkg::*;

  grc_cmd_t    cmd;
  grc_status_t st;

  assign cfg_ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .st(st), .cmd(cmd)
  );

  grc_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .item(item),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );
endmodule
`default_nettype wire

/* rtl/core/grc_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module grc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [15:0] rem;
  logic [15:0] dreg;
  logic [5:0]  cnt;
  logic        run;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem, quo[31]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
        dreg <= den;
      end else if (run) begin
        rem <= ge ? 16'(trial - {1'b0, dreg}) : trial[15:0];
        quo <= {quo[30:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/grc_sqrt.sv */
// Serial integer square root (floor), two radicand bits per cycle.
`default_nettype none
module grc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] radicand,
  output logic        done,
  output logic [16:0] root
);
  logic [33:0] rv;
  logic [33:0] res;
  logic [33:0] probe;
  logic        run;
  logic [34:0] sum;
  logic        ge;

  assign sum  = {1'b0, res} + {1'b0, probe};
  assign ge   = {1'b0, rv} >= sum;
  assign root = res[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        rv    <= radicand;
        res   <= '0;
        probe <= 34'h1_0000_0000;
      end else if (run) begin
        if (ge) begin
          rv  <= 34'(rv - sum[33:0]);
          res <= (res >> 1) + probe;
        end else begin
          res <= res >> 1;
        end
        probe <= probe >> 2;
        if (probe[0]) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/grc_dpath.sv */
// Datapath: registers, shared multiplier, trace arithmetic and result register.
`default_nettype none
module grc_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  grc_pkg::grc_cmd_t    cmd,
  output grc_pkg::grc_status_t st,
  input  grc_pkg::grc_in_t     item,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 result_valid,
  output grc_pkg::grc_out_t    result
);
  import grc_pkg::*;

  logic [31:0] map_lo, map_hi;
  logic [9:0]  scr_h;
  logic [6:0]  ray_cnt;
  logic [7:0]  ang_step;
  logic [10:0] half_fov;

  logic [15:0] px, py;
  logic [ANGLE_BITS-1:0] pa, ray_ang;
  logic [5:0]  col;
  logic [6:0]  n_rays;

  logic signed [19:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [37:0] prod;

  logic [14:0] sin_z, sin_z2;
  logic        sin_neg;
  ang_sel_t    sin_sel;
  logic signed [15:0] sval, cval, ccval;

  logic [15:0] tr_va, tr_vb;
  logic signed [15:0] tr_da, tr_db;
  logic signed [18:0] tr_pos;
  logic        div_neg;

  logic [15:0] hx, hy, vx, vy, rx, ry;
  logic        hit_h, hit_v, side, miss;
  logic [33:0] hd2, vd2, d2, d2_acc;
  logic [15:0] ray_dist;
  logic [9:0]  height;

  logic        div_start, div_done, sq_done;
  logic [31:0] div_num, div_quo;
  logic [15:0] div_den;
  logic [16:0] root;

  logic [ANGLE_BITS-1:0] ang;
  logic [15:0] phase;
  logic [14:0] zsel, prod_q14, t1, t2;
  logic signed [15:0] fval, da_sel, db_sel;
  logic [15:0] va_sel, vb_sel;
  logic signed [18:0] base, diff;
  logic        da_pos;
  logic signed [37:0] negp;
  logic [31:0] mag;
  logic [15:0] den_mag;
  logic signed [33:0] qs, rb;
  logic        wall;
  logic [15:0] wx, wy, hitx_sel, hity_sel;
  logic signed [16:0] dx, dy;
  logic [63:0] map64;
  logic        pick_v;
  logic [33:0] d2_sum;

  grc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  grc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.op == OP_SQ_GO), .radicand(d2),
    .done(sq_done), .root(root)
  );

  always_comb begin
    case (cmd.sel)
      SEL_S:   ang = ray_ang;
      SEL_C:   ang = ray_ang + QUARTER;
      default: ang = pa - ray_ang + QUARTER;
    endcase
    phase    = 16'(ang) << ANG_SHIFT;
    zsel     = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    prod_q14 = prod[28:14];
    t1       = 15'(15'd10512 - prod_q14);
    t2       = 15'(15'd25736 - prod_q14);
    fval     = sin_neg ? -$signed({1'b0, prod_q14}) : $signed({1'b0, prod_q14});

    va_sel = cmd.axis_v ? px : py;
    vb_sel = cmd.axis_v ? py : px;
    da_sel = cmd.axis_v ? cval : -sval;
    db_sel = cmd.axis_v ? -sval : cval;
    base   = $signed({3'b000, va_sel[15:CELL_SHIFT], {CELL_SHIFT{1'b0}}});
    da_pos = !tr_da[15] && (tr_da != 16'sd0);
    diff   = tr_pos - $signed({3'b000, tr_va});

    negp    = -prod;
    mag     = prod[37] ? negp[31:0] : prod[31:0];
    den_mag = tr_da[15] ? 16'(-tr_da) : tr_da;

    qs    = div_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    rb    = $signed({18'd0, tr_vb}) + qs;
    wx    = cmd.axis_v ? tr_pos[15:0] : rb[15:0];
    wy    = cmd.axis_v ? rb[15:0] : tr_pos[15:0];
    map64 = {map_hi, map_lo};
    wall  = (rb[33:16] == '0) && (tr_pos[18:16] == '0) &&
            map64[{wy[CELL_SHIFT +: MAP_BITS], wx[CELL_SHIFT +: MAP_BITS]}];

    hitx_sel = cmd.axis_v ? vx : hx;
    hity_sel = cmd.axis_v ? vy : hy;
    dx       = $signed({1'b0, hitx_sel}) - $signed({1'b0, px});
    dy       = $signed({1'b0, hity_sel}) - $signed({1'b0, py});
    d2_sum   = d2_acc + prod[33:0];
    pick_v   = hit_v && (!hit_h || vd2 < hd2);

    div_start = (cmd.op == OP_TR_DIV) || (cmd.op == OP_HD_GO && ray_dist != 16'd0);
    div_num   = (cmd.op == OP_TR_DIV) ? mag : {10'd0, scr_h, 12'd0};
    div_den   = (cmd.op == OP_TR_DIV) ? den_mag : ray_dist;
  end

  always_comb begin
    st.cnt_zero  = ray_cnt == 7'd0;
    st.da_zero   = da_sel == 16'sd0;
    st.wall      = wall;
    st.div_done  = div_done;
    st.sqrt_done = sq_done;
    st.miss      = !hit_h && !hit_v;
    st.dist_zero = ray_dist == 16'd0;
    st.last      = ({1'b0, col} + 7'd1) == n_rays;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_lo       <= WALL_LO_RST;
      map_hi       <= WALL_HI_RST;
      scr_h        <= SCR_H_RST;
      ray_cnt      <= RAY_CNT_RST;
      ang_step     <= ANG_STEP_RST;
      half_fov     <= HALF_FOV_RST;
      result_valid <= 1'b0;
      hit_h        <= 1'b0;
      hit_v        <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_WALL_LO:  map_lo   <= cfg_data;
          REG_WALL_HI:  map_hi   <= cfg_data;
          REG_SCR_H:    scr_h    <= cfg_data[9:0];
          REG_RAY_CNT:  ray_cnt  <= cfg_data[6:0];
          REG_ANG_STEP: ang_step <= cfg_data[7:0];
          REG_HALF_FOV: half_fov <= cfg_data[10:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          px      <= item.viewer_x;
          py      <= item.viewer_y;
          pa      <= ANGLE_BITS'(item.viewer_angle);
          ray_ang <= ANGLE_BITS'(item.viewer_angle) + ANGLE_BITS'(half_fov);
          col     <= '0;
          n_rays  <= (ray_cnt > 7'(MAX_RAYS)) ? 7'(MAX_RAYS) : ray_cnt;
        end
        OP_SIN_SET: begin
          sin_z   <= zsel;
          sin_neg <= phase[15];
          sin_sel <= cmd.sel;
          mul_a   <= $signed({5'd0, zsel});
          mul_b   <= $signed({3'd0, zsel});
        end
        OP_SIN_Z2: begin
          sin_z2 <= prod_q14;
          mul_a  <= 20'sd1160;
          mul_b  <= $signed({3'd0, prod_q14});
        end
        OP_SIN_T1: begin
          mul_a <= $signed({5'd0, sin_z2});
          mul_b <= $signed({3'd0, t1});
        end
        OP_SIN_T2: begin
          mul_a <= $signed({5'd0, sin_z});
          mul_b <= $signed({3'd0, t2});
        end
        OP_SIN_END: begin
          case (sin_sel)
            SEL_S:   sval  <= fval;
            SEL_C:   cval  <= fval;
            default: ccval <= fval;
          endcase
        end
        OP_TR_INIT: begin
          tr_va <= va_sel;
          tr_vb <= vb_sel;
          tr_da <= da_sel;
          tr_db <= db_sel;
          if (!da_sel[15]) tr_pos <= base + 19'(CELL_Q);
          else tr_pos <= base - 19'sd1;
          if (cmd.axis_v) hit_v <= 1'b0;
          else hit_h <= 1'b0;
        end
        OP_TR_MUL: begin
          mul_a <= {diff[18], diff};
          mul_b <= {{2{tr_db[15]}}, tr_db};
        end
        OP_TR_DIV: div_neg <= prod[37] ^ tr_da[15];
        OP_TR_TEST: begin
          if (wall) begin
            if (cmd.axis_v) begin
              vx <= tr_pos[15:0];
              vy <= rb[15:0];
              hit_v <= 1'b1;
            end else begin
              hy <= tr_pos[15:0];
              hx <= rb[15:0];
              hit_h <= 1'b1;
            end
          end else begin
            tr_pos <= da_pos ? tr_pos + 19'(CELL_Q) : tr_pos - 19'(CELL_Q);
          end
        end
        OP_D2_A: begin
          mul_a <= 20'(dx);
          mul_b <= 18'(dx);
        end
        OP_D2_B: begin
          d2_acc <= prod[33:0];
          mul_a  <= 20'(dy);
          mul_b  <= 18'(dy);
        end
        OP_D2_C: begin
          if (cmd.axis_v) vd2 <= d2_sum;
          else hd2 <= d2_sum;
        end
        OP_SELECT: begin
          miss <= 1'b0;
          if (pick_v) begin
            rx <= vx; ry <= vy; d2 <= vd2; side <= 1'b0;
          end else if (hit_h) begin
            rx <= hx; ry <= hy; d2 <= hd2; side <= 1'b1;
          end else begin
            rx <= px; ry <= py; side <= 1'b1; miss <= 1'b1;
            ray_dist <= 16'hFFFF; height <= '0;
          end
        end
        OP_DM_MUL: begin
          mul_a <= $signed({3'd0, root});
          mul_b <= {{2{ccval[15]}}, ccval};
        end
        OP_DIST: begin
          if (ccval[15] || ccval == 16'sd0) ray_dist <= '0;
          else if (prod[37:31] != '0) ray_dist <= 16'hFFFF;
          else ray_dist <= prod[30:15];
        end
        OP_HD_GO: if (ray_dist == 16'd0) height <= scr_h;
        OP_HEIGHT: height <= (div_quo > {22'd0, scr_h}) ? scr_h : div_quo[9:0];
        OP_EMIT: begin
          result_valid        <= 1'b1;
          result.column       <= col;
          result.hit_x        <= rx;
          result.hit_y        <= ry;
          result.wall_side    <= side;
          result.no_hit       <= miss;
          result.distance     <= ray_dist;
          result.slice_height <= height;
          result.slice_offset <= 9'(scr_h[9:1] - height[9:1]);
          result.last_ray     <= st.last;
          ray_ang             <= ray_ang - ANGLE_BITS'(ang_step);
          col                 <= col + 6'd1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/grc_ctrl.sv */
// Controller: sequences sine evaluation, both traces, distance and height per ray.
`default_nettype none
module grc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  grc_pkg::grc_status_t st,
  output grc_pkg::grc_cmd_t    cmd
);
  import grc_pkg::*;

  typedef enum logic [4:0] {
    IDLE, SIN_SET, SIN_W1, SIN_Z2, SIN_W2, SIN_T1, SIN_W3, SIN_T2, SIN_W4, SIN_END,
    TR_INIT, TR_MUL, TR_W, TR_DIV, TR_DWAIT, TR_TEST,
    D2_A, D2_W1, D2_B, D2_W2, D2_C,
    SELECT, SQ_GO, SQ_WAIT, DM_MUL, DM_W, DIST, HD_GO, HD_WAIT, HEIGHT, EMIT
  } state_t;

  state_t            state, state_next;
  ang_sel_t          sel, sel_next;
  logic              axis, axis_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    axis_next  = axis;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.sel    = sel;
    cmd.axis_v = axis;
    case (state)
      IDLE: if (start) begin
        cmd.op = OP_LOAD;
        if (!st.cnt_zero) begin
          sel_next   = SEL_S;
          state_next = SIN_SET;
        end
      end
      SIN_SET: begin cmd.op = OP_SIN_SET; state_next = SIN_W1; end
      SIN_W1:  state_next = SIN_Z2;
      SIN_Z2:  begin cmd.op = OP_SIN_Z2; state_next = SIN_W2; end
      SIN_W2:  state_next = SIN_T1;
      SIN_T1:  begin cmd.op = OP_SIN_T1; state_next = SIN_W3; end
      SIN_W3:  state_next = SIN_T2;
      SIN_T2:  begin cmd.op = OP_SIN_T2; state_next = SIN_W4; end
      SIN_W4:  state_next = SIN_END;
      SIN_END: begin
        cmd.op = OP_SIN_END;
        case (sel)
          SEL_S: begin sel_next = SEL_C; state_next = SIN_SET; end
          SEL_C: begin axis_next = 1'b0; state_next = TR_INIT; end
          default: state_next = SQ_GO;
        endcase
      end
      TR_INIT: begin
        cmd.op   = OP_TR_INIT;
        cnt_next = '0;
        if (!st.da_zero) state_next = TR_MUL;
        else if (!axis) axis_next = 1'b1;
        else state_next = SELECT;
      end
      TR_MUL:   begin cmd.op = OP_TR_MUL; state_next = TR_W; end
      TR_W:     state_next = TR_DIV;
      TR_DIV:   begin cmd.op = OP_TR_DIV; state_next = TR_DWAIT; end
      TR_DWAIT: if (st.div_done) state_next = TR_TEST;
      TR_TEST: begin
        cmd.op = OP_TR_TEST;
        if (st.wall) state_next = D2_A;
        else if (cnt != STEP_W'(MAX_STEPS - 1)) begin
          cnt_next   = cnt + STEP_W'(1);
          state_next = TR_MUL;
        end else if (!axis) begin
          axis_next  = 1'b1;
          state_next = TR_INIT;
        end else state_next = SELECT;
      end
      D2_A:  begin cmd.op = OP_D2_A; state_next = D2_W1; end
      D2_W1: state_next = D2_B;
      D2_B:  begin cmd.op = OP_D2_B; state_next = D2_W2; end
      D2_W2: state_next = D2_C;
      D2_C: begin
        cmd.op = OP_D2_C;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = TR_INIT;
        end else state_next = SELECT;
      end
      SELECT: begin
        cmd.op = OP_SELECT;
        if (st.miss) state_next = EMIT;
        else begin
          sel_next   = SEL_D;
          state_next = SIN_SET;
        end
      end
      SQ_GO:   begin cmd.op = OP_SQ_GO; state_next = SQ_WAIT; end
      SQ_WAIT: if (st.sqrt_done) state_next = DM_MUL;
      DM_MUL:  begin cmd.op = OP_DM_MUL; state_next = DM_W; end
      DM_W:    state_next = DIST;
      DIST:    begin cmd.op = OP_DIST; state_next = HD_GO; end
      HD_GO: begin
        cmd.op     = OP_HD_GO;
        state_next = st.dist_zero ? EMIT : HD_WAIT;
      end
      HD_WAIT: if (st.div_done) state_next = HEIGHT;
      HEIGHT:  begin cmd.op = OP_HEIGHT; state_next = EMIT; end
      EMIT: begin
        cmd.op = OP_EMIT;
        if (st.last) state_next = IDLE;
        else begin
          sel_next   = SEL_S;
          state_next = SIN_SET;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      sel   <= SEL_S;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      busy  <= state_next != IDLE;
      sel   <= sel_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/grc_checker.sv */
// Port-level assertions for the ray caster and their bind to the top level.
`default_nettype none
module grc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input grc_pkg::grc_out_t result
);
  import grc_pkg::*;

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result beats in consecutive cycles");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.no_hit |-> result.distance == 16'hFFFF &&
      result.slice_height == 10'd0 && result.wall_side)
    else $error("miss beat with wrong fields");

  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_ray |-> busy)
    else $error("not busy with rays still pending");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(busy) |-> $past(start))
    else $error("busy rose without a start beat");
endmodule

bind grid_ray_caster_unit grc_checker u_grc_checker (.*);
`default_nettype wire
